// ===== hw/rtl/tmhq_pkg.sv =====
// ---------------------------------------------------------------------------
// tmhq_pkg: shared types and constants for the timer min-heap queue
// Widths, command and result codes, queue entry type.
// ---------------------------------------------------------------------------
package tmhq_pkg;
	localparam int Capacity = 32;
	localparam int IdW = 5;
	localparam int CntW = 6;
	localparam int TimeW = 63;
	localparam int IvlW = 40;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_STOP = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_NOP  = 2'd3;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_STOP = 2'd1;
	localparam logic [1:0] KIND_FIRE = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_NOTFD = 2'd2;

	typedef struct packed {
		logic [1:0]       command;
		logic [IdW-1:0]   timer_id;
		logic [TimeW-1:0] expiry_time;
		logic [IvlW-1:0]  interval_us;
		logic [TimeW-1:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       status;
		logic [IdW-1:0]   result_id;
		logic             is_earliest;
		logic             has_deadline;
		logic [TimeW-1:0] next_deadline;
		logic             last;
	} res_t;
endpackage

// ===== hw/rtl/tmhq_cmd_if.sv =====
// ---------------------------------------------------------------------------
// tmhq_cmd_if: command channel
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface tmhq_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    command;
	logic [tmhq_pkg::IdW-1:0]      timer_id;
	logic [tmhq_pkg::TimeW-1:0]    expiry_time;
	logic [tmhq_pkg::IvlW-1:0]     interval_us;
	logic [tmhq_pkg::TimeW-1:0]    now_time;
	modport source (output valid, command, timer_id, expiry_time, interval_us, now_time,
		input ready);
	modport sink (input valid, command, timer_id, expiry_time, interval_us, now_time,
		output ready);
endinterface

// ===== hw/rtl/tmhq_res_if.sv =====
// ---------------------------------------------------------------------------
// tmhq_res_if: result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface tmhq_res_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [1:0]                 status;
	logic [tmhq_pkg::IdW-1:0]   result_id;
	logic                       is_earliest;
	logic                       has_deadline;
	logic [tmhq_pkg::TimeW-1:0] next_deadline;
	logic                       last;
	modport source (output valid, kind, status, result_id, is_earliest, has_deadline,
		next_deadline, last, input ready);
	modport sink (input valid, kind, status, result_id, is_earliest, has_deadline,
		next_deadline, last, output ready);
endinterface

// ===== hw/rtl/tmhq_front.sv =====
// ---------------------------------------------------------------------------
// tmhq_front: command intake and queue
// Two-entry queue that takes command items and drops code three (NOP).
// ---------------------------------------------------------------------------
module tmhq_front (
	input  logic               clk,
	input  logic               arst_n,
	tmhq_cmd_if.sink           cmd,
	output logic               q_valid,
	output tmhq_pkg::cmd_t     q_data,
	input  logic               q_pop
);
	tmhq_pkg::cmd_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign cmd.ready = (cnt_q != 2'd2);
	// drop command three at the door
	assign push = cmd.valid && cmd.ready && (cmd.command != tmhq_pkg::CMD_NOP);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{cmd.command, cmd.timer_id, cmd.expiry_time,
				cmd.interval_us, cmd.now_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// ===== hw/rtl/tmhq_back.sv =====
// ---------------------------------------------------------------------------
// tmhq_back: heap engine
// Sequencer that runs add, stop and tick over the heap memories.
// ---------------------------------------------------------------------------
module tmhq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tmhq_pkg::cmd_t     q_data,
	output logic               q_pop,
	tmhq_res_if.source         res
);
	localparam int IdW = tmhq_pkg::IdW;
	localparam int CntW = tmhq_pkg::CntW;
	localparam int TimeW = tmhq_pkg::TimeW;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_DISP  = 12'b000000000010,
		S_INS   = 12'b000000000100,
		S_UP    = 12'b000000001000,
		S_RM    = 12'b000000010000,
		S_RM2   = 12'b000000100000,
		S_DOWN  = 12'b000001000000,
		S_TICK  = 12'b000010000000,
		S_REARM = 12'b000100000000,
		S_DONE  = 12'b001000000000,
		S_EMIT  = 12'b010000000000,
		S_WAIT  = 12'b100000000000
	} state_t;

	// heap stores: slots are flip-flop arrays read at computed places
	logic [TimeW-1:0]         exp_q   [tmhq_pkg::Capacity];
	logic [tmhq_pkg::IvlW-1:0] ivl_q  [tmhq_pkg::Capacity];
	logic [IdW-1:0]           hslot_q [tmhq_pkg::Capacity];
	logic [IdW-1:0]           hpos_q  [tmhq_pkg::Capacity];
	logic [tmhq_pkg::Capacity-1:0] live_q;
	logic [CntW-1:0]          cnt_q;

	state_t          st_q, ret_q;
	tmhq_pkg::cmd_t  c_q;
	tmhq_pkg::res_t  r_q;
	logic            rv_q;
	logic [CntW-1:0] i_q;
	logic [IdW-1:0]  fired_q [tmhq_pkg::Capacity];
	logic [CntW-1:0] nf_q, k_q;

	logic [CntW-1:0] par, lc, rc, m, last_idx;
	logic [TimeW-1:0] ki, kp, kl, kr, km;
	logic            free_ok;
	logic [IdW-1:0]  free_id;
	logic [TimeW:0]  rearm_sum;
	logic [TimeW-1:0] rearm;
	logic [IdW-1:0]  fs;
	logic            res_free, tick_pop, rv_set;

	function automatic tmhq_pkg::res_t mk_res(logic [1:0] kind, logic [1:0] status,
			logic [IdW-1:0] id, logic earl, logic hasdl, logic [TimeW-1:0] dl,
			logic fin);
		tmhq_pkg::res_t r;
		r.kind = kind;
		r.status = status;
		r.result_id = id;
		r.is_earliest = earl;
		r.has_deadline = hasdl;
		r.next_deadline = dl;
		r.last = fin;
		return r;
	endfunction

	assign par = (i_q - 6'd1) >> 1;
	assign lc = {i_q[CntW-2:0], 1'b1};
	assign rc = lc + 6'd1;
	assign last_idx = cnt_q - 6'd1;
	assign ki = exp_q[hslot_q[i_q[IdW-1:0]]];
	assign kp = exp_q[hslot_q[par[IdW-1:0]]];
	assign kl = exp_q[hslot_q[lc[IdW-1:0]]];
	assign kr = exp_q[hslot_q[rc[IdW-1:0]]];
	assign m = ((rc == cnt_q) || (kl < kr)) ? lc : rc;
	assign km = exp_q[hslot_q[m[IdW-1:0]]];
	assign fs = fired_q[k_q[IdW-1:0]];
	assign rearm_sum = {1'b0, c_q.now_time} + {{(TimeW+1-tmhq_pkg::IvlW){1'b0}}, ivl_q[fs]};
	assign rearm = rearm_sum[TimeW] ? tmhq_pkg::TimeMax : rearm_sum[TimeW-1:0];

	// result register is free when empty or handed over at this edge
	assign res_free = !rv_q || res.ready;
	assign tick_pop = (cnt_q != '0) && (exp_q[hslot_q[0]] < c_q.now_time);
	assign rv_set = res_free && ((st_q == S_WAIT) || ((st_q == S_TICK) && tick_pop));

	always_comb begin
		free_ok = 1'b0;
		free_id = '0;
		for (int s = tmhq_pkg::Capacity - 1; s >= 0; s--) begin
			if (!live_q[s]) begin
				free_ok = 1'b1;
				free_id = IdW'(s);
			end
		end
	end

	assign q_pop = (st_q == S_IDLE) && q_valid && res_free;
	assign res.valid = rv_q;
	assign res.kind = r_q.kind;
	assign res.status = r_q.status;
	assign res.result_id = r_q.result_id;
	assign res.is_earliest = r_q.is_earliest;
	assign res.has_deadline = r_q.has_deadline;
	assign res.next_deadline = r_q.next_deadline;
	assign res.last = r_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			rv_q <= 1'b0;
			live_q <= '0;
			cnt_q <= '0;
		end else begin
			rv_q <= rv_set || (rv_q && !res.ready);
			unique case (st_q)
				S_IDLE: begin
					if (q_valid && res_free) begin
						c_q <= q_data;
						st_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (c_q.command)
						tmhq_pkg::CMD_ADD: begin
							if (!free_ok) begin
								r_q <= mk_res(tmhq_pkg::KIND_ADD, tmhq_pkg::ST_FULL, '0,
									1'b0, 1'b0, '0, 1'b1);
								st_q <= S_EMIT;
								ret_q <= S_IDLE;
							end else begin
								live_q[free_id] <= 1'b1;
								exp_q[free_id] <= c_q.expiry_time;
								ivl_q[free_id] <= c_q.interval_us;
								r_q <= mk_res(tmhq_pkg::KIND_ADD, tmhq_pkg::ST_OK, free_id,
									(cnt_q == '0) || (c_q.expiry_time < exp_q[hslot_q[0]]),
									1'b0, '0, 1'b1);
								c_q.timer_id <= free_id;
								ret_q <= S_EMIT;
								st_q <= S_INS;
							end
						end
						tmhq_pkg::CMD_STOP: begin
							if (live_q[c_q.timer_id]) begin
								r_q <= mk_res(tmhq_pkg::KIND_STOP, tmhq_pkg::ST_OK,
									c_q.timer_id, 1'b0, 1'b0, '0, 1'b1);
								live_q[c_q.timer_id] <= 1'b0;
								i_q <= {1'b0, hpos_q[c_q.timer_id]};
								ret_q <= S_EMIT;
								st_q <= S_RM;
							end else begin
								r_q <= mk_res(tmhq_pkg::KIND_STOP, tmhq_pkg::ST_NOTFD,
									c_q.timer_id, 1'b0, 1'b0, '0, 1'b1);
								ret_q <= S_IDLE;
								st_q <= S_EMIT;
							end
						end
						default: begin
							nf_q <= '0;
							k_q <= '0;
							st_q <= S_TICK;
						end
					endcase
				end
				// append slot c_q.timer_id at the tail, then sift up
				S_INS: begin
					hslot_q[cnt_q[IdW-1:0]] <= c_q.timer_id;
					hpos_q[c_q.timer_id] <= cnt_q[IdW-1:0];
					i_q <= cnt_q;
					cnt_q <= cnt_q + 6'd1;
					st_q <= S_UP;
				end
				S_UP: begin
					if (i_q != '0 && ki < kp) begin
						hslot_q[i_q[IdW-1:0]] <= hslot_q[par[IdW-1:0]];
						hslot_q[par[IdW-1:0]] <= hslot_q[i_q[IdW-1:0]];
						hpos_q[hslot_q[par[IdW-1:0]]] <= i_q[IdW-1:0];
						hpos_q[hslot_q[i_q[IdW-1:0]]] <= par[IdW-1:0];
						i_q <= par;
					end else begin
						st_q <= ret_q;
					end
				end
				// remove heap index i_q: move tail in, shrink
				S_RM: begin
					if (i_q == last_idx) begin
						cnt_q <= last_idx;
						st_q <= ret_q;
					end else begin
						hslot_q[i_q[IdW-1:0]] <= hslot_q[last_idx[IdW-1:0]];
						hslot_q[last_idx[IdW-1:0]] <= hslot_q[i_q[IdW-1:0]];
						hpos_q[hslot_q[last_idx[IdW-1:0]]] <= i_q[IdW-1:0];
						hpos_q[hslot_q[i_q[IdW-1:0]]] <= last_idx[IdW-1:0];
						cnt_q <= last_idx;
						st_q <= S_RM2;
					end
				end
				S_RM2: begin
					st_q <= (i_q != '0 && ki < kp) ? S_UP : S_DOWN;
				end
				S_DOWN: begin
					if (lc < cnt_q && !(ki < km)) begin
						hslot_q[i_q[IdW-1:0]] <= hslot_q[m[IdW-1:0]];
						hslot_q[m[IdW-1:0]] <= hslot_q[i_q[IdW-1:0]];
						hpos_q[hslot_q[m[IdW-1:0]]] <= i_q[IdW-1:0];
						hpos_q[hslot_q[i_q[IdW-1:0]]] <= m[IdW-1:0];
						i_q <= m;
					end else begin
						st_q <= ret_q;
					end
				end
				// pop expired roots, emitting one fire item each
				S_TICK: begin
					if (tick_pop) begin
						if (res_free) begin
							fired_q[nf_q[IdW-1:0]] <= hslot_q[0];
							nf_q <= nf_q + 6'd1;
							r_q <= mk_res(tmhq_pkg::KIND_FIRE, tmhq_pkg::ST_OK, hslot_q[0],
								1'b0, 1'b0, '0, 1'b0);
							i_q <= '0;
							ret_q <= S_TICK;
							st_q <= S_RM;
						end
					end else begin
						st_q <= S_REARM;
					end
				end
				S_REARM: begin
					if (k_q == nf_q) begin
						st_q <= S_DONE;
					end else begin
						k_q <= k_q + 6'd1;
						if (ivl_q[fs] != '0) begin
							exp_q[fs] <= rearm;
							c_q.timer_id <= fs;
							ret_q <= S_REARM;
							st_q <= S_INS;
						end else begin
							live_q[fs] <= 1'b0;
						end
					end
				end
				// hold until the last fire item has left the result register
				S_DONE: begin
					if (res_free) begin
						r_q <= mk_res(tmhq_pkg::KIND_DONE, tmhq_pkg::ST_OK, '0, 1'b0,
							cnt_q != '0, (cnt_q != '0) ? exp_q[hslot_q[0]] : '0, 1'b1);
						ret_q <= S_IDLE;
						st_q <= S_WAIT;
					end
				end
				S_EMIT: begin
					st_q <= S_WAIT;
				end
				S_WAIT: begin
					if (res_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/timer_min_heap_queue.sv =====
// ---------------------------------------------------------------------------
// timer_min_heap_queue: binary min-heap timer queue
// Top level joining the command front end and the heap engine.
// ---------------------------------------------------------------------------
// Use: drive command items on cmd (add, stop, tick). Each add and stop gives
// one reply item on res; a tick gives one fire item per expired timer in
// expiry order, then a tick-done item with the next deadline. The last item
// of every command carries last=1. Command code three is dropped silently.
// A command leaves the two-entry front queue and runs in the heap engine;
// an add or stop that changes the heap sifts the timer into place before
// its reply, and a tick pops every expired timer, then re-arms or frees
// each one. The sift loop of the heap engine moves one level per cycle.
// Commands are taken one at a time by the engine; the front queue lets up to
// two more wait. Reset clears all timers and both queues at once. When the
// receiver stalls, the result register holds its item and the engine waits.
// ---------------------------------------------------------------------------
module timer_min_heap_queue (
	input  logic      clk,
	input  logic      arst_n,
	tmhq_cmd_if.sink  cmd,
	tmhq_res_if.source res
);
	logic            q_valid, q_pop;
	tmhq_pkg::cmd_t  q_data;

	// hold incoming items in the queue
	tmhq_front u_front (.clk, .arst_n, .cmd, .q_valid, .q_data, .q_pop);
	// advance the heap work and drive results
	tmhq_back u_back (.clk, .arst_n, .q_valid, .q_data, .q_pop, .res);
endmodule

// ===== hw/rtl/tmhq_checker.sv =====
// ---------------------------------------------------------------------------
// tmhq_checker: port checks for the timer queue
// Watches the result channel for legal item shapes.
// ---------------------------------------------------------------------------
module tmhq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic       res_last,
	input logic       res_has_deadline,
	input logic       res_is_earliest
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind))
		else $error("result dropped while stalled");
	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == tmhq_pkg::KIND_FIRE |-> !res_last)
		else $error("fire item marked last");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != tmhq_pkg::KIND_FIRE |-> res_last)
		else $error("reply item not last");
	a_dl_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_has_deadline |-> res_kind == tmhq_pkg::KIND_DONE)
		else $error("deadline outside tick done");
	a_earl_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_is_earliest |-> res_kind == tmhq_pkg::KIND_ADD)
		else $error("earliest flag outside add");
endmodule

bind timer_min_heap_queue tmhq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.res_kind(res.kind), .res_last(res.last), .res_has_deadline(res.has_deadline),
	.res_is_earliest(res.is_earliest));

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench for the timer min-heap queue
// Feeds add, stop and tick items through the command channel with bursty
// valid and a stalling result receiver. A heap predictor in the bench tracks
// every live timer and works out the replies, fire items and tick-done item
// that each accepted command must produce. Each result is checked in order.
// ---------------------------------------------------------------------------
module tb_top;
	localparam int Capacity = tmhq_pkg::Capacity;
	localparam int IdW = tmhq_pkg::IdW;
	localparam int TimeW = tmhq_pkg::TimeW;
	localparam int IvlW = tmhq_pkg::IvlW;
	localparam logic [TimeW-1:0] TimeMax = tmhq_pkg::TimeMax;
	localparam int IdleLimit = 20000;
	localparam int DrainCycles = 60;
	localparam logic [IvlW-1:0] IvlMax = {IvlW{1'b1}};

	logic clk;
	logic arst_n;

	tmhq_cmd_if cmd ();
	tmhq_res_if res ();

	timer_min_heap_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Timer heap predictor: slot stores, heap array and position map
	// ------------------------------------------------------------------
	logic [TimeW-1:0] tmr_expiry [Capacity];
	logic [IvlW-1:0]  tmr_ivl    [Capacity];
	logic [IdW-1:0]   heap_slot  [Capacity];
	logic [IdW-1:0]   heap_pos   [Capacity];
	logic             tmr_live   [Capacity];
	int               heap_cnt;

	tmhq_pkg::res_t expected_results [$];
	tmhq_pkg::cmd_t pending_cmds [$];
	bit   failed;

	function automatic void expect_item(tmhq_pkg::res_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic logic [TimeW-1:0] key_of(int idx);
		return tmr_expiry[heap_slot[idx]];
	endfunction

	function automatic void heap_swap(int a, int b);
		logic [IdW-1:0] t;
		t = heap_slot[a];
		heap_slot[a] = heap_slot[b];
		heap_slot[b] = t;
		heap_pos[heap_slot[a]] = a[IdW-1:0];
		heap_pos[heap_slot[b]] = b[IdW-1:0];
	endfunction

	// Rise only past strictly later parents, so equal keys keep their order.
	function automatic void sift_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (key_of(i) < key_of(p)) begin
				heap_swap(i, p);
				i = p;
			end else begin
				break;
			end
		end
	endfunction

	// Take the left child only if strictly earlier; stop only if strictly earlier.
	function automatic void sift_down(int i);
		int c, m;
		c = 2 * i + 1;
		while (c < heap_cnt) begin
			if (c + 1 == heap_cnt || key_of(c) < key_of(c + 1)) m = c;
			else m = c + 1;
			if (key_of(i) < key_of(m)) break;
			heap_swap(i, m);
			i = m;
			c = 2 * i + 1;
		end
	endfunction

	function automatic bit heap_push(int slot);
		bit earliest;
		earliest = (heap_cnt == 0) || (tmr_expiry[slot] < key_of(0));
		heap_slot[heap_cnt] = slot[IdW-1:0];
		heap_pos[slot] = heap_cnt[IdW-1:0];
		heap_cnt++;
		sift_up(heap_cnt - 1);
		return earliest;
	endfunction

	function automatic void heap_drop(int idx);
		if (heap_cnt == 0 || idx >= heap_cnt) return;
		if (idx == heap_cnt - 1) begin
			heap_cnt--;
			return;
		end
		heap_swap(idx, heap_cnt - 1);
		heap_cnt--;
		if (idx > 0 && key_of(idx) < key_of((idx - 1) / 2)) sift_up(idx);
		else sift_down(idx);
	endfunction

	function automatic tmhq_pkg::res_t make_result(logic [1:0] kind, logic [1:0] status,
			logic [IdW-1:0] id, bit earliest, bit has_dl, logic [TimeW-1:0] dl, bit fin);
		tmhq_pkg::res_t r;
		r.kind = kind;
		r.status = status;
		r.result_id = id;
		r.is_earliest = earliest;
		r.has_deadline = has_dl;
		r.next_deadline = dl;
		r.last = fin;
		return r;
	endfunction

	// Work out every result that one accepted command must produce.
	function automatic void predict_timers(tmhq_pkg::cmd_t c);
		int slot, n;
		logic [IdW-1:0] fired [Capacity];
		bit earliest;
		logic [TimeW:0] sum;
		case (c.command)
			tmhq_pkg::CMD_ADD: begin
				slot = Capacity;
				for (int s = Capacity - 1; s >= 0; s--) if (!tmr_live[s]) slot = s;
				if (slot >= Capacity || heap_cnt >= Capacity) begin
					expect_item(make_result(tmhq_pkg::KIND_ADD, tmhq_pkg::ST_FULL, '0,
						1'b0, 1'b0, '0, 1'b1));
				end else begin
					tmr_live[slot] = 1'b1;
					tmr_expiry[slot] = c.expiry_time;
					tmr_ivl[slot] = c.interval_us;
					earliest = heap_push(slot);
					expect_item(make_result(tmhq_pkg::KIND_ADD, tmhq_pkg::ST_OK,
						slot[IdW-1:0], earliest, 1'b0, '0, 1'b1));
				end
			end
			tmhq_pkg::CMD_STOP: begin
				if (tmr_live[c.timer_id]) begin
					heap_drop(int'(heap_pos[c.timer_id]));
					tmr_live[c.timer_id] = 1'b0;
					expect_item(make_result(tmhq_pkg::KIND_STOP, tmhq_pkg::ST_OK,
						c.timer_id, 1'b0, 1'b0, '0, 1'b1));
				end else begin
					expect_item(make_result(tmhq_pkg::KIND_STOP, tmhq_pkg::ST_NOTFD,
						c.timer_id, 1'b0, 1'b0, '0, 1'b1));
				end
			end
			tmhq_pkg::CMD_TICK: begin
				n = 0;
				// Pop everything strictly before now, report, then re-arm or free.
				while (heap_cnt > 0 && key_of(0) < c.now_time && n < Capacity) begin
					fired[n] = heap_slot[0];
					n++;
					heap_drop(0);
				end
				for (int i = 0; i < n; i++)
					expect_item(make_result(tmhq_pkg::KIND_FIRE, tmhq_pkg::ST_OK, fired[i],
						1'b0, 1'b0, '0, 1'b0));
				for (int i = 0; i < n; i++) begin
					if (tmr_ivl[fired[i]] != '0) begin
						sum = {1'b0, c.now_time} +
							{{(TimeW+1-IvlW){1'b0}}, tmr_ivl[fired[i]]};
						tmr_expiry[fired[i]] = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
						void'(heap_push(int'(fired[i])));
					end else begin
						tmr_live[fired[i]] = 1'b0;
					end
				end
				if (heap_cnt > 0)
					expect_item(make_result(tmhq_pkg::KIND_DONE, tmhq_pkg::ST_OK, '0,
						1'b0, 1'b1, key_of(0), 1'b1));
				else
					expect_item(make_result(tmhq_pkg::KIND_DONE, tmhq_pkg::ST_OK, '0,
						1'b0, 1'b0, '0, 1'b1));
			end
			default: ;  // code three: no results
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of items from the pending queue, random gaps between
	// ------------------------------------------------------------------
	logic cmd_took;
	int   burst_left;
	int   gap_left;

	always @(negedge clk) begin
		tmhq_pkg::cmd_t it;
		if (arst_n && (!cmd.valid || cmd_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				it = pending_cmds.pop_front();
				cmd.command <= it.command;
				cmd.timer_id <= it.timer_id;
				cmd.expiry_time <= it.expiry_time;
				cmd.interval_us <= it.interval_us;
				cmd.now_time <= it.now_time;
				cmd.valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: the mode cycles in turn through
	// always ready, coin flip and mostly stalled.
	int stall_cyc;

	always @(negedge clk) begin
		int mode;
		if (arst_n) begin
			stall_cyc++;
			mode = (stall_cyc / 64) % 3;
			case (mode)
				0: res.ready <= 1'b1;
				1: res.ready <= 1'($urandom_range(0, 1));
				default: res.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predict on command accept, check each accepted result
	// ------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		tmhq_pkg::cmd_t c;
		tmhq_pkg::res_t want;
		cmd_took <= cmd.valid && cmd.ready;
		if (arst_n) begin
			if (cmd.valid && cmd.ready) begin
				c.command = cmd.command;
				c.timer_id = cmd.timer_id;
				c.expiry_time = cmd.expiry_time;
				c.interval_us = cmd.interval_us;
				c.now_time = cmd.now_time;
				predict_timers(c);
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d id=%0d", $time, res.kind,
						res.result_id);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (res.kind !== want.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, want.kind, res.kind);
						failed = 1'b1;
					end
					if (res.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							res.status);
						failed = 1'b1;
					end
					if (res.result_id !== want.result_id) begin
						$display("%0t: result_id expected %0d actual %0d", $time,
							want.result_id, res.result_id);
						failed = 1'b1;
					end
					if (res.is_earliest !== want.is_earliest) begin
						$display("%0t: is_earliest expected %0d actual %0d", $time,
							want.is_earliest, res.is_earliest);
						failed = 1'b1;
					end
					if (res.has_deadline !== want.has_deadline) begin
						$display("%0t: has_deadline expected %0d actual %0d", $time,
							want.has_deadline, res.has_deadline);
						failed = 1'b1;
					end
					if (res.next_deadline !== want.next_deadline) begin
						$display("%0t: next_deadline expected %0d actual %0d", $time,
							want.next_deadline, res.next_deadline);
						failed = 1'b1;
					end
					if (res.last !== want.last) begin
						$display("%0t: last expected %0d actual %0d", $time, want.last, res.last);
						failed = 1'b1;
					end
				end
			end
			// Watchdog: count cycles in which neither channel moves an item.
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_cmd(logic [1:0] op, logic [IdW-1:0] id, logic [TimeW-1:0] exp_t,
			logic [IvlW-1:0] ivl, logic [TimeW-1:0] now_t);
		tmhq_pkg::cmd_t c;
		c.command = op;
		c.timer_id = id;
		c.expiry_time = exp_t;
		c.interval_us = ivl;
		c.now_time = now_t;
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic logic [TimeW-1:0] wide_time();
		return TimeW'({$urandom, $urandom});
	endfunction

	initial begin
		logic [TimeW-1:0] base_t;
		logic [TimeW-1:0] exp_t;
		logic [TimeW-1:0] now_t;
		logic [IvlW-1:0]  ivl;
		int pick;
		int add_pct;

		failed = 1'b0;
		heap_cnt = 0;
		for (int i = 0; i < Capacity; i++) tmr_live[i] = 1'b0;
		burst_left = 4;
		gap_left = 0;
		stall_cyc = 0;
		idle_cycles = 0;
		cmd_took = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.command = tmhq_pkg::CMD_ADD;
		cmd.timer_id = '0;
		cmd.expiry_time = '0;
		cmd.interval_us = '0;
		cmd.now_time = '0;
		res.ready = 1'b0;

		// Directed: empty ticks, field extremes, equal expiries, unknown ids,
		// code three, firing, and re-arm saturation.
		queue_cmd(tmhq_pkg::CMD_TICK, '0, '0, '0, '0);
		queue_cmd(tmhq_pkg::CMD_TICK, '1, '1, '1, TimeMax);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, 63'd100, '0, '0);
		queue_cmd(tmhq_pkg::CMD_ADD, '1, 63'd100, 40'd50, '1);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, 63'd50, IvlMax, '0);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, TimeMax, '0, '0);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, '0, 40'd1, '0);
		queue_cmd(tmhq_pkg::CMD_STOP, 5'd31, '0, '0, '0);
		queue_cmd(tmhq_pkg::CMD_STOP, 5'd1, '0, '0, '0);
		queue_cmd(tmhq_pkg::CMD_STOP, 5'd1, '0, '0, '0);
		queue_cmd(tmhq_pkg::CMD_NOP, '1, '1, '1, '1);
		queue_cmd(tmhq_pkg::CMD_TICK, '0, '0, '0, 63'd100);
		queue_cmd(tmhq_pkg::CMD_TICK, '0, '0, '0, 63'd101);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, 63'd100, 40'd7, '0);
		queue_cmd(tmhq_pkg::CMD_ADD, '0, 63'd100, 40'd7, '0);
		queue_cmd(tmhq_pkg::CMD_TICK, '0, '0, '0, TimeMax - 63'd5);
		queue_cmd(tmhq_pkg::CMD_TICK, '0, '0, '0, TimeMax);
		queue_cmd(tmhq_pkg::CMD_STOP, 5'd3, '0, '0, '0);
		queue_cmd(tmhq_pkg::CMD_STOP, 5'd0, '0, '0, '0);

		// Random: alternate fill-heavy and drain-heavy stretches so the store
		// runs full and empty; times cluster near a moving base for collisions.
		base_t = 63'd1000;
		for (int k = 0; k < 250; k++) begin
			add_pct = ((k / 50) % 2 == 0) ? 85 : 30;
			pick = $urandom_range(0, 99);
			ivl = ($urandom_range(0, 2) == 0) ? '0 : IvlW'($urandom_range(1, 300));
			if ($urandom_range(0, 15) == 0) ivl = IvlW'({$urandom, $urandom});
			exp_t = base_t + TimeW'($urandom_range(0, 200));
			if ($urandom_range(0, 15) == 0) exp_t = wide_time();
			now_t = base_t + TimeW'($urandom_range(0, 300));
			if ($urandom_range(0, 31) == 0) now_t = wide_time();
			if (pick < add_pct) begin
				queue_cmd(tmhq_pkg::CMD_ADD, IdW'($urandom), exp_t, ivl, wide_time());
			end else if (pick < add_pct + (100 - add_pct) / 2) begin
				queue_cmd(tmhq_pkg::CMD_STOP, IdW'($urandom), wide_time(),
					IvlW'({$urandom, $urandom}), wide_time());
			end else begin
				queue_cmd(tmhq_pkg::CMD_TICK, IdW'($urandom), wide_time(),
					IvlW'({$urandom, $urandom}), now_t);
				base_t = base_t + TimeW'($urandom_range(0, 150));
			end
			if ($urandom_range(0, 40) == 0)
				queue_cmd(tmhq_pkg::CMD_NOP, IdW'($urandom), wide_time(), '0, '0);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() > 0 || cmd.valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (!failed) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
